// File: rtl/core/rqh_pkg.sv
// Shared types, constants and the symbol decoder for the rolling q-gram hash core.
// No dependencies; used by every module of the core except rqh_checker.
package rqh_pkg;

   typedef logic [1:0] mode_type;
   typedef logic [5:0] sym_type;
   typedef logic [0:0] csr_addr_type;

   localparam mode_type MODE_DNA   = 2'd0;
   localparam mode_type MODE_ALPHA = 2'd1;
   localparam mode_type MODE_MIXED = 2'd2;

   localparam csr_addr_type CSR_ALPHABET_MODE = 1'b0;
   localparam csr_addr_type CSR_WINDOW_LEN    = 1'b1;

   localparam mode_type  MODE_RESET = MODE_MIXED;
   localparam logic [3:0] WLEN_RESET = 4'd5;

   localparam logic [31:0] HASH_MULT = 32'd2654435761;
   localparam logic [31:0] HASH_MOD  = 32'hFFFF_FFFF;

   localparam int QUEUE_DEPTH = 4;

   localparam sym_type CODE_DIGIT_BASE = 6'd27;
   localparam sym_type CODE_SPACE      = 6'd37;

   function automatic sym_type sym_code(input mode_type mode, input logic [7:0] c);
      sym_type code;
      code = '0;
      if (mode == MODE_DNA) begin
         case (c)
            "C":     code = 6'd1;
            "G":     code = 6'd2;
            "T":     code = 6'd3;
            "N":     code = 6'd4;
            default: code = 6'd0;
         endcase
      end else if (c >= "A" && c <= "Z") begin
         code = 6'(c - 8'd64);
      end else if (c >= "a" && c <= "z") begin
         code = 6'(c - 8'd96);
      end else if (mode != MODE_ALPHA && c >= "0" && c <= "9") begin
         code = 6'(c - 8'd48) + CODE_DIGIT_BASE;
      end else if (mode != MODE_ALPHA && c == " ") begin
         code = CODE_SPACE;
      end
      return code;
   endfunction

endpackage

// File: rtl/core/rolling_qgram_hash_core.sv
// Rolling q-gram hash core: accepts one character per cycle while the queue is not full and,
// once the window is full, returns (window * 2654435761) mod (2^32 - 1) for each character.
// The front end updates the window as each character is accepted; a four-entry queue plus a
// three-stage hash pipeline (fold, 32x32 multiply, fold) let either side stall on its own.
// Depends on rqh_pkg, rqh_front, rqh_fifo and rqh_back.
module rolling_qgram_hash_core #(
   parameter int MAX_WINDOW_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  rqh_pkg::csr_addr_type csr_addr,
   input  logic [3:0]            csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_byte
   input  logic                  req_tuser,   // [0] first_of_string
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata    // [31:0] gram_hash
);

   logic                       push, pop, queue_valid, queue_full;
   logic [MAX_WINDOW_BITS-1:0] push_window, queue_window;

   rqh_front #(.MAX_WINDOW_BITS(MAX_WINDOW_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .char_byte       (req_tdata),
      .first_of_string (req_tuser),
      .push            (push),
      .push_window     (push_window),
      .queue_full      (queue_full)
   );

   rqh_fifo #(.WIDTH(MAX_WINDOW_BITS)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_window),
      .pop       (pop),
      .pop_valid (queue_valid),
      .pop_data  (queue_window),
      .full      (queue_full)
   );

   rqh_back #(.MAX_WINDOW_BITS(MAX_WINDOW_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_valid  (queue_valid),
      .queue_window (queue_window),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_hash     (rsp_tdata)
   );

endmodule

// File: rtl/core/rqh_fifo.sv
// Small register queue between the window front end and the hash back end.
// Depends on rqh_pkg for the queue depth.
module rqh_fifo #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   output logic             full
);

   localparam int PTR_W = $clog2(rqh_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(rqh_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [rqh_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;
   assign pop_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(rqh_pkg::QUEUE_DEPTH));
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/rqh_front.sv
// Front end: configuration registers, symbol mapping, window shift and fill count.
// Depends on rqh_pkg; pushes full windows into the queue.
module rqh_front #(
   parameter int MAX_WINDOW_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  rqh_pkg::csr_addr_type      csr_addr,
   input  logic [3:0]                 csr_wdata,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [7:0]                 char_byte,
   input  logic                       first_of_string,
   output logic                       push,
   output logic [MAX_WINDOW_BITS-1:0] push_window,
   input  logic                       queue_full
);

   localparam int W = MAX_WINDOW_BITS;
   localparam logic [3:0] CAP_DNA   = 4'(((W / 3) > 15) ? 15 : (W / 3));
   localparam logic [3:0] CAP_ALPHA = 4'(((W / 5) > 15) ? 15 : (W / 5));
   localparam logic [3:0] CAP_MIXED = 4'(((W / 6) > 15) ? 15 : (W / 6));

   rqh_pkg::mode_type mode_ff;
   logic [3:0]        wlen_ff;
   logic [W-1:0]      window_ff, window_in;
   logic [3:0]        fill_ff, fill_in;

   logic [2:0]        bits;
   logic [3:0]        cap, len, base_fill;
   logic [6:0]        nbits;
   logic [W:0]        one_sh;
   logic [W-1:0]      mask, base, shifted;
   rqh_pkg::sym_type  code;
   logic              accept, emit;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      unique case (mode_ff)
         rqh_pkg::MODE_DNA: begin
            bits = 3'd3;
            cap  = CAP_DNA;
         end
         rqh_pkg::MODE_ALPHA: begin
            bits = 3'd5;
            cap  = CAP_ALPHA;
         end
         default: begin
            bits = 3'd6;
            cap  = CAP_MIXED;
         end
      endcase

      len = (wlen_ff == 4'd0) ? 4'd1 : wlen_ff;
      if (len > cap) begin
         len = cap;
      end
      nbits  = 7'(len) * 7'(bits);
      one_sh = (W + 1)'(1) << nbits;
      mask   = W'(one_sh - 1'b1);

      // first character of a string starts from an empty window
      base = first_of_string ? '0 : window_ff;
      unique case (mode_ff)
         rqh_pkg::MODE_DNA:   shifted = base << 3;
         rqh_pkg::MODE_ALPHA: shifted = base << 5;
         default:             shifted = base << 6;
      endcase
      code      = rqh_pkg::sym_code(mode_ff, char_byte);
      window_in = (shifted | W'(code)) & mask;

      base_fill = first_of_string ? 4'd0 : fill_ff;
      fill_in   = (base_fill < len) ? base_fill + 4'd1 : len;
      emit      = (fill_in == len);
   end

   assign push        = accept && emit;
   assign push_window = window_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= rqh_pkg::MODE_RESET;
         wlen_ff   <= rqh_pkg::WLEN_RESET;
         window_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               rqh_pkg::CSR_ALPHABET_MODE: mode_ff <= csr_wdata[1:0];
               rqh_pkg::CSR_WINDOW_LEN:    wlen_ff <= csr_wdata;
               default:                    ;
            endcase
         end
         if (accept) begin
            window_ff <= window_in;
            fill_ff   <= fill_in;
         end
      end
   end

endmodule

// File: rtl/core/rqh_back.sv
// Back end: three-stage elastic pipeline computing window * multiplier mod (2^32 - 1).
// Depends on rqh_pkg for the hash constants; pops windows from the queue.
module rqh_back #(
   parameter int MAX_WINDOW_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_valid,
   input  logic [MAX_WINDOW_BITS-1:0] queue_window,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [31:0]                rsp_hash
);

   localparam int NCH = (MAX_WINDOW_BITS + 31) / 32;

   // end-around fold of a value below 2^34 into the residue mod 2^32 - 1
   function automatic logic [31:0] fold_mod(input logic [33:0] s);
      logic [32:0] f1;
      logic [31:0] f2;
      f1 = 33'(s[31:0]) + 33'(s[33:32]);
      f2 = f1[31:0] + 32'(f1[32]);
      return (f2 == rqh_pkg::HASH_MOD) ? 32'd0 : f2;
   endfunction

   logic              v1_ff, v2_ff, v3_ff;
   logic              rdy1, rdy2, rdy3;
   logic [31:0]       a_ff, a_in;
   logic [63:0]       prod_ff;
   logic [31:0]       hash_ff, hash_in;
   logic [NCH*32-1:0] ext;
   logic [33:0]       chunk_sum;

   assign rdy3 = !v3_ff || rsp_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign pop  = queue_valid && rdy1;

   always_comb begin
      ext       = (NCH * 32)'(queue_window);
      chunk_sum = '0;
      for (int i = 0; i < NCH; i++) begin
         chunk_sum = chunk_sum + 34'(ext[i*32 +: 32]);
      end
      a_in    = fold_mod(chunk_sum);
      hash_in = fold_mod(34'(prod_ff[63:32]) + 34'(prod_ff[31:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= queue_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_ff <= a_in;
      end
      if (rdy2 && v1_ff) begin
         prod_ff <= 64'(a_ff) * 64'(rqh_pkg::HASH_MULT);
      end
      if (rdy3 && v2_ff) begin
         hash_ff <= hash_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_hash  = hash_ff;

endmodule

// File: rtl/core/rqh_checker.sv
// Port-level checker for rolling_qgram_hash_core, attached with a bind statement.
// Depends only on the top level's ports.
module rqh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a residue mod 2^32 - 1 never reaches all ones
   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 32'hFFFF_FFFF)
      else $error("gram_hash out of range");

   // reset empties the result pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("stalled beat dropped");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled beat changed");

endmodule

bind rolling_qgram_hash_core rqh_checker u_rqh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/rolling_qgram_hash_monitor.sv
// Scoreboard for the rolling q-gram hash core: follows CSR writes and accepted characters,
// predicts each gram_hash beat and compares it with the result channel. Depends on rqh_pkg.
module rolling_qgram_hash_monitor (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  rqh_pkg::csr_addr_type csr_addr,
   input  logic [3:0]            csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_byte
   input  logic                  req_tuser,   // [0] first_of_string
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [31:0]           rsp_tdata,   // [31:0] gram_hash
   output int                    fail_total,
   output int                    hashes_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_BITS = 32;
   localparam logic [63:0] MOD_WIDE  = {32'd0, rqh_pkg::HASH_MOD};
   localparam logic [63:0] MULT_WIDE = {32'd0, rqh_pkg::HASH_MULT};

   rqh_pkg::mode_type alpha_mode;
   logic [3:0]        wlen_reg;
   logic [63:0]       shift_window;
   int                fill_level;
   int                fails;
   logic [31:0]       expected_hashes[$];

   function automatic int bits_per_symbol(input rqh_pkg::mode_type m);
      if (m == rqh_pkg::MODE_DNA) return 3;
      if (m == rqh_pkg::MODE_ALPHA) return 5;
      return 6;
   endfunction

   function automatic logic [5:0] symbol_of(input rqh_pkg::mode_type m,
                                            input logic [7:0] c);
      if (m == rqh_pkg::MODE_DNA) begin
         // lower-case bases and anything else fold onto the code of 'A'
         case (c)
            "C":     return 6'd1;
            "G":     return 6'd2;
            "T":     return 6'd3;
            "N":     return 6'd4;
            default: return 6'd0;
         endcase
      end
      if (c >= "A" && c <= "Z") return 6'(c - "A" + 1);
      if (c >= "a" && c <= "z") return 6'(c - "a" + 1);
      if (m == rqh_pkg::MODE_ALPHA) return 6'd0;
      if (c >= "0" && c <= "9") return 6'(c - "0") + rqh_pkg::CODE_DIGIT_BASE;
      if (c == " ") return rqh_pkg::CODE_SPACE;
      return 6'd0;
   endfunction

   task automatic absorb_char(input logic [7:0] c, input logic first);
      int          bits;
      int          span;
      int          len;
      logic [63:0] folded;
      logic [63:0] product;
      bits = bits_per_symbol(alpha_mode);
      span = WINDOW_BITS / bits;
      len  = (wlen_reg == 4'd0) ? 1 : int'(wlen_reg);
      if (len > span) len = span;
      if (first) begin
         shift_window = '0;
         fill_level   = 0;
      end
      shift_window = ((shift_window << bits) | 64'(symbol_of(alpha_mode, c)))
                     & ((64'd1 << (len * bits)) - 64'd1);
      if (fill_level < len) fill_level++;
      if (fill_level > len) fill_level = len;
      if (fill_level == len) begin
         folded  = shift_window % MOD_WIDE;
         product = folded * MULT_WIDE;
         expected_hashes = {expected_hashes, 32'(product % MOD_WIDE)};
      end
   endtask

   always @(posedge clock) begin : track
      logic [31:0] want;
      if (reset) begin
         alpha_mode   = rqh_pkg::MODE_RESET;
         wlen_reg     = rqh_pkg::WLEN_RESET;
         shift_window = '0;
         fill_level   = 0;
         fails        = 0;
         expected_hashes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hashes.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected gram_hash beat %h", $realtime, rsp_tdata);
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_tdata !== want) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: gram_hash mismatch: expected %h, actual %h",
                              $realtime, want, rsp_tdata);
               end
            end
         end
         if (csr_we) begin
            if (csr_addr == rqh_pkg::CSR_ALPHABET_MODE) alpha_mode = csr_wdata[1:0];
            else if (csr_addr == rqh_pkg::CSR_WINDOW_LEN) wlen_reg = csr_wdata;
         end
         if (req_tvalid && req_tready) absorb_char(req_tdata, req_tuser);
      end
      fail_total  <= fails;
      hashes_owed <= expected_hashes.size();
   end

endmodule

// File: tb/rolling_qgram_hash_core_tb.sv
// Top of the rolling q-gram hash core testbench: clock, reset, CSR writes, character
// stimulus and result back-pressure. Depends on rqh_pkg, the core and rolling_qgram_hash_monitor.
module rolling_qgram_hash_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int RANDOM_ITEMS = 1400;
   localparam rqh_pkg::mode_type MODE_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   rqh_pkg::csr_addr_type csr_addr = rqh_pkg::CSR_ALPHABET_MODE;
   logic [3:0]            csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [7:0] char_byte
   logic                  req_tuser = 1'b0; // [0] first_of_string
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;        // [31:0] gram_hash

   int fail_total;
   int hashes_owed;
   int cycles = 0;
   int chars_sent = 0;
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   rolling_qgram_hash_core dut (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   rolling_qgram_hash_monitor u_monitor (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .fail_total, .hashes_owed
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none at all in calm stretches
   function automatic int gap_len(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   initial begin : rx_pressure
      int hold;
      int stall;
      forever begin
         hold  = $urandom_range(1, 12);
         stall = gap_len(rx_calm);
         rsp_tready <= 1'b1;
         repeat (hold) @(posedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   task automatic send_char(input logic [7:0] c, input logic first);
      int gap;
      gap = gap_len(tx_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input logic first_at_start);
      for (int i = 0; i < s.len(); i++) send_char(s[i], first_at_start && i == 0);
   endtask

   // drop valid, let every owed hash arrive, then cover items that produce no beat
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hashes_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(input rqh_pkg::mode_type mode, input logic [3:0] len);
      wait_idle();
      csr_we    <= 1'b1;
      csr_addr  <= rqh_pkg::CSR_ALPHABET_MODE;
      csr_wdata <= {2'b00, mode};
      @(posedge clock);
      csr_addr  <= rqh_pkg::CSR_WINDOW_LEN;
      csr_wdata <= len;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] random_char(input rqh_pkg::mode_type mode);
      string pool;
      if ($urandom_range(0, 99) < 30) return 8'($urandom_range(0, 255));
      if (mode == rqh_pkg::MODE_DNA) pool = "ACGTN";
      else if (mode == rqh_pkg::MODE_ALPHA)
         pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
      else pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 ";
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   initial begin : stimulus
      int                phase;
      int                run;
      int                left;
      rqh_pkg::mode_type mode_v;
      logic [3:0]        len_v;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset configuration: mixed alphabet, five symbols
      tx_calm = 1'b1;
      send_text("AZaz09 ", 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_char("{", 1'b1);
      // DNA with an oversized window; carry the old window across the change
      set_config(rqh_pkg::MODE_DNA, 4'd15);
      tx_calm = 1'b0;
      send_text("ACGTNacgtN", 1'b0);
      // spare mode and zero length
      set_config(MODE_SPARE, 4'd0);
      send_text("z5", 1'b0);
      send_char(" ", 1'b1);

      chars_sent = 0;
      phase = 0;
      while (chars_sent < RANDOM_ITEMS) begin
         case (phase)
            0: begin mode_v = rqh_pkg::MODE_ALPHA; len_v = 4'd6;  end
            1: begin mode_v = rqh_pkg::MODE_MIXED; len_v = 4'd5;  end
            2: begin mode_v = rqh_pkg::MODE_DNA;   len_v = 4'd10; end
            3: begin mode_v = rqh_pkg::MODE_DNA;   len_v = 4'd1;  end
            4: begin mode_v = rqh_pkg::MODE_ALPHA; len_v = 4'd15; end
            5: begin mode_v = rqh_pkg::MODE_MIXED; len_v = 4'd0;  end
            default: begin
               mode_v = rqh_pkg::mode_type'($urandom_range(0, 3));
               len_v  = 4'($urandom_range(0, 15));
            end
         endcase
         set_config(mode_v, len_v);
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         run  = $urandom_range(40, 150);
         // a nonzero start continues the string from the previous setting
         left = $urandom_range(0, 12);
         repeat (run) begin
            if (left == 0) begin
               left = $urandom_range(1, 30);
               send_char(random_char(mode_v), 1'b1);
            end else begin
               send_char(random_char(mode_v), 1'b0);
            end
            left--;
         end
         phase++;
      end

      wait_idle();
      if (fail_total == 0 && hashes_owed == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: rolling_qgram_hash_core.f
rtl/core/rqh_pkg.sv
rtl/core/rqh_fifo.sv
rtl/core/rqh_front.sv
rtl/core/rqh_back.sv
rtl/core/rolling_qgram_hash_core.sv
rtl/core/rqh_checker.sv
tb/rolling_qgram_hash_monitor.sv
tb/rolling_qgram_hash_core_tb.sv
